// ===== design/kpe_pkg.sv =====
// Shared types, microcode encodings and arrangement operations of the k-permutation enumerator.
package kpe_pkg;

    // sizing
    localparam int MAX_SYMBOLS = 4;
    localparam int IDX_W       = $clog2(MAX_SYMBOLS);
    localparam int POS_W       = $clog2(MAX_SYMBOLS + 1);
    localparam int LEN_W       = 3;
    localparam int CNT_W       = 3;
    localparam int PC_W        = 4;

    // program addresses
    localparam logic [PC_W-1:0] PC_ENTRY    = 4'd0;
    localparam logic [PC_W-1:0] PC_ORD_SCAN = 4'd1;
    localparam logic [PC_W-1:0] PC_ORD_SWAP = 4'd2;
    localparam logic [PC_W-1:0] PC_ORD_REV  = 4'd3;
    localparam logic [PC_W-1:0] PC_WRAP_REV = 4'd4;
    localparam logic [PC_W-1:0] PC_SEL_SCAN = 4'd5;
    localparam logic [PC_W-1:0] PC_SEL_SWAP = 4'd6;
    localparam logic [PC_W-1:0] PC_ROT_A    = 4'd7;
    localparam logic [PC_W-1:0] PC_ROT_B    = 4'd8;
    localparam logic [PC_W-1:0] PC_GROW     = 4'd9;
    localparam logic [PC_W-1:0] PC_FULL_CHK = 4'd10;
    localparam logic [PC_W-1:0] PC_FULL_SCN = 4'd11;
    localparam logic [PC_W-1:0] PC_FULL_SWP = 4'd12;
    localparam logic [PC_W-1:0] PC_FINISH   = 4'd13;

    // configuration register addresses
    localparam logic [1:0] ADDR_SYMBOL_COUNT = 2'd0;

    typedef logic [MAX_SYMBOLS-1:0][IDX_W-1:0] t_arr;

    // datapath operations
    typedef enum logic [3:0] {
        OP_NOP,
        OP_ENTRY,
        OP_ORD_SCAN,
        OP_ORD_SWAP,
        OP_REV,
        OP_SEL_SCAN,
        OP_SEL_SWAP,
        OP_ROT_A,
        OP_ROT_B,
        OP_GROW,
        OP_FINISH
    } t_op;

    // jump conditions
    typedef enum logic [2:0] {
        C_NEVER,
        C_ALWAYS,
        C_DEAD,
        C_NO_PIVOT,
        C_NO_SEL,
        C_GROW_OVER,
        C_LEN_NE_N
    } t_cond;

    typedef struct packed {
        t_op              op;
        t_cond            cond;
        logic [PC_W-1:0]  target;
    } t_uword;

    // sequencer to datapath / top
    typedef struct packed {
        t_op  op;
        logic emit;
    } t_ctl;

    // datapath status seen by the jump logic
    typedef struct packed {
        logic dead;
        logic no_pivot;
        logic no_sel;
        logic grow_over;
        logic len_ne_n;
    } t_flags;

    typedef struct packed {
        logic [LEN_W-1:0] tuple_length;
        t_arr             indices;
        logic             tuple_valid;
        logic             final_tuple;
    } t_result;

    function automatic t_arr f_ascending();
        t_arr a;
        for (int i = 0; i < MAX_SYMBOLS; i++) begin
            a[i] = IDX_W'(i);
        end
        return a;
    endfunction

    // one past the ordering pivot, 0 when the prefix is non-increasing
    function automatic int f_ord_lo(t_arr a, int len);
        int lo;
        lo = 0;
        for (int i = 1; i < MAX_SYMBOLS; i++) begin
            if (i < len && a[i-1] < a[i]) begin
                lo = i;
            end
        end
        return lo;
    endfunction

    // rightmost element above the pivot
    function automatic int f_ord_j(t_arr a, int len, int p);
        int j;
        j = p;
        for (int i = 0; i < MAX_SYMBOLS; i++) begin
            if (i > p && i < len && a[p] < a[i]) begin
                j = i;
            end
        end
        return j;
    endfunction

    function automatic t_arr f_swap(t_arr a, int x, int y);
        t_arr o;
        o    = a;
        o[x] = a[y];
        o[y] = a[x];
        return o;
    endfunction

    function automatic t_arr f_reverse(t_arr a, int lo, int hi);
        t_arr o;
        o = a;
        for (int p = 0; p < MAX_SYMBOLS; p++) begin
            if (p >= lo && p < hi) begin
                o[p] = a[lo + hi - 1 - p];
            end
        end
        return o;
    endfunction

    // brings a[mid..hi) in front of a[lo..mid)
    function automatic t_arr f_rotate(t_arr a, int lo, int mid, int hi);
        t_arr o;
        int   q;
        int   l2;
        o  = a;
        l2 = hi - mid;
        if (lo < mid && mid < hi && hi <= MAX_SYMBOLS) begin
            for (int p = 0; p < MAX_SYMBOLS; p++) begin
                q = p - lo;
                if (p >= lo && p < hi) begin
                    if (q < l2) begin
                        o[p] = a[mid + q];
                    end else begin
                        o[p] = a[lo + q - l2];
                    end
                end
            end
        end
        return o;
    endfunction

    // one past the combination element to bump, 0 when none
    function automatic int f_sel_lo(t_arr a, int k, int n);
        int lo;
        lo = 0;
        if (n >= 2 && k != 0 && k < n) begin
            for (int i = 0; i < MAX_SYMBOLS; i++) begin
                if (i < k && a[i] < a[n-1]) begin
                    lo = i + 1;
                end
            end
        end
        return lo;
    endfunction

    // first unchosen element above a[x], else the last one
    function automatic int f_sel_j(t_arr a, int k, int n, int x);
        int j;
        j = n - 1;
        for (int i = MAX_SYMBOLS - 1; i >= 0; i--) begin
            if (i >= k && i < n - 1 && a[x] < a[i]) begin
                j = i;
            end
        end
        return j;
    endfunction

endpackage

// ===== design/kpe_useq.sv =====
// Microcode sequencer: program table, step counter and conditional jumps.
module kpe_useq
    import kpe_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_start,
    input  logic   i_out_free,
    input  t_flags i_flags,
    output logic   o_busy,
    output t_ctl   o_ctl
);

    logic            r_busy, n_busy;
    logic [PC_W-1:0] r_pc, n_pc;
    t_uword          w_uw;
    logic            w_hit;

    // program table
    always_comb begin
        case (r_pc)
            PC_ENTRY:    w_uw = '{OP_ENTRY,    C_DEAD,      PC_FINISH};
            PC_ORD_SCAN: w_uw = '{OP_ORD_SCAN, C_NO_PIVOT,  PC_WRAP_REV};
            PC_ORD_SWAP: w_uw = '{OP_ORD_SWAP, C_NEVER,     PC_ENTRY};
            PC_ORD_REV:  w_uw = '{OP_REV,      C_ALWAYS,    PC_FINISH};
            PC_WRAP_REV: w_uw = '{OP_REV,      C_NEVER,     PC_ENTRY};
            PC_SEL_SCAN: w_uw = '{OP_SEL_SCAN, C_NO_SEL,    PC_GROW};
            PC_SEL_SWAP: w_uw = '{OP_SEL_SWAP, C_NEVER,     PC_ENTRY};
            PC_ROT_A:    w_uw = '{OP_ROT_A,    C_NEVER,     PC_ENTRY};
            PC_ROT_B:    w_uw = '{OP_ROT_B,    C_ALWAYS,    PC_FINISH};
            PC_GROW:     w_uw = '{OP_GROW,     C_GROW_OVER, PC_FINISH};
            PC_FULL_CHK: w_uw = '{OP_NOP,      C_LEN_NE_N,  PC_FINISH};
            PC_FULL_SCN: w_uw = '{OP_ORD_SCAN, C_NO_PIVOT,  PC_ORD_REV};
            PC_FULL_SWP: w_uw = '{OP_ORD_SWAP, C_ALWAYS,    PC_ORD_REV};
            PC_FINISH:   w_uw = '{OP_FINISH,   C_NEVER,     PC_FINISH};
            default:     w_uw = '{OP_FINISH,   C_NEVER,     PC_FINISH};
        endcase
    end

    // jump condition select
    always_comb begin
        case (w_uw.cond)
            C_NEVER:     w_hit = 1'b0;
            C_ALWAYS:    w_hit = 1'b1;
            C_DEAD:      w_hit = i_flags.dead;
            C_NO_PIVOT:  w_hit = i_flags.no_pivot;
            C_NO_SEL:    w_hit = i_flags.no_sel;
            C_GROW_OVER: w_hit = i_flags.grow_over;
            C_LEN_NE_N:  w_hit = i_flags.len_ne_n;
            default:     w_hit = 1'b0;
        endcase
    end

    // step counter and control word issue
    always_comb begin
        n_busy     = r_busy;
        n_pc       = r_pc;
        o_ctl.op   = OP_NOP;
        o_ctl.emit = 1'b0;
        if (r_busy) begin
            if (w_uw.op == OP_FINISH) begin
                if (i_out_free) begin
                    n_busy     = 1'b0;
                    o_ctl.emit = 1'b1;
                end
            end else begin
                o_ctl.op = w_uw.op;
                n_pc     = w_hit ? w_uw.target : r_pc + 1'b1;
            end
        end else if (i_start) begin
            n_busy = 1'b1;
            n_pc   = PC_ENTRY;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_pc   <= PC_ENTRY;
        end else begin
            r_busy <= n_busy;
            r_pc   <= n_pc;
        end
    end

    assign o_busy = r_busy;

endmodule

// ===== design/kpe_dpath.sv =====
// Datapath: stored arrangement, length, exhausted flag and the per-step operations.
module kpe_dpath
    import kpe_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic             i_restart,
    input  logic [CNT_W-1:0] i_symbol_count,
    input  t_ctl             i_ctl,
    output t_flags           o_flags,
    output t_result          o_result
);

    t_arr             r_arr;
    logic [LEN_W-1:0] r_len;
    logic             r_exh;
    logic             r_final;
    logic             r_restart;
    logic [POS_W-1:0] r_lo;
    logic [POS_W-1:0] r_j;
    t_result          r_cap;

    logic [LEN_W-1:0] w_n;
    t_arr             w_v_arr;
    logic [LEN_W-1:0] w_v_len;
    logic             w_v_exh;
    logic             w_dead;
    int               w_ord_lo;
    int               w_sel_lo;
    logic [IDX_W-1:0] w_piv;
    int               w_ord_j;
    int               w_sel_j;
    logic [LEN_W:0]   w_len_inc;

    // effective symbol count, clamped to 1..MAX_SYMBOLS
    always_comb begin
        if (i_symbol_count == '0) begin
            w_n = LEN_W'(1);
        end else if (i_symbol_count > CNT_W'(MAX_SYMBOLS)) begin
            w_n = LEN_W'(MAX_SYMBOLS);
        end else begin
            w_n = i_symbol_count;
        end
    end

    // state as seen by the request, after an optional restart
    always_comb begin
        w_v_arr = r_restart ? f_ascending() : r_arr;
        w_v_len = r_restart ? LEN_W'(1) : r_len;
        w_v_exh = r_restart ? 1'b0 : r_exh;
        w_dead  = w_v_exh || (w_v_len == '0) || (w_v_len > w_n);
    end

    // scans over the stored arrangement
    always_comb begin
        w_ord_lo  = f_ord_lo(r_arr, int'(r_len));
        w_sel_lo  = f_sel_lo(r_arr, int'(r_len), int'(w_n));
        w_piv     = IDX_W'(r_lo - 1'b1);
        w_ord_j   = f_ord_j(r_arr, int'(r_len), int'(w_piv));
        w_sel_j   = f_sel_j(r_arr, int'(r_len), int'(w_n), int'(w_piv));
        w_len_inc = {1'b0, r_len} + 1'b1;
    end

    assign o_flags.dead      = w_dead;
    assign o_flags.no_pivot  = (w_ord_lo == 0);
    assign o_flags.no_sel    = (w_sel_lo == 0);
    assign o_flags.grow_over = (w_len_inc > {1'b0, w_n});
    assign o_flags.len_ne_n  = (r_len != w_n);

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_arr     <= f_ascending();
            r_len     <= LEN_W'(1);
            r_exh     <= 1'b0;
            r_final   <= 1'b0;
            r_restart <= 1'b0;
            r_lo      <= '0;
            r_j       <= '0;
        end else begin
            if (i_start) begin
                r_restart <= i_restart;
            end
            case (i_ctl.op)
                OP_ENTRY: begin
                    r_arr     <= w_v_arr;
                    r_len     <= w_v_len;
                    r_exh     <= w_dead;
                    r_final   <= 1'b0;
                    r_restart <= 1'b0;
                end
                OP_ORD_SCAN: begin
                    r_lo <= POS_W'(w_ord_lo);
                end
                OP_ORD_SWAP: begin
                    r_arr <= f_swap(r_arr, int'(w_piv), w_ord_j);
                end
                OP_REV: begin
                    r_arr <= f_reverse(r_arr, int'(r_lo), int'(r_len));
                end
                OP_SEL_SCAN: begin
                    r_lo <= POS_W'(w_sel_lo);
                end
                OP_SEL_SWAP: begin
                    r_arr <= f_swap(r_arr, int'(w_piv), w_sel_j);
                    r_j   <= POS_W'(w_sel_j + 1);
                end
                OP_ROT_A: begin
                    r_arr <= f_rotate(r_arr, int'(r_lo), int'(r_j), int'(w_n));
                end
                OP_ROT_B: begin
                    r_arr <= f_rotate(r_arr, int'(r_len),
                                      int'(r_len) + int'(w_n) - int'(r_j), int'(w_n));
                end
                OP_GROW: begin
                    if (w_len_inc > {1'b0, w_n}) begin
                        r_exh   <= 1'b1;
                        r_final <= 1'b1;
                    end else begin
                        r_len <= LEN_W'(w_len_inc);
                        r_arr <= f_ascending();
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // tuple capture before advancing; exhausted requests give all zeros
    always_ff @(posedge i_clk) begin
        if (i_ctl.op == OP_ENTRY) begin
            r_cap.tuple_length <= w_dead ? '0 : w_v_len;
            r_cap.tuple_valid  <= !w_dead;
            // last flag is known only after advancing, taken from r_final at the output
            r_cap.final_tuple  <= 1'b0;
            for (int t = 0; t < MAX_SYMBOLS; t++) begin
                r_cap.indices[t] <= (!w_dead && t < int'(w_v_len)) ? w_v_arr[t] : '0;
            end
        end
    end

    always_comb begin
        o_result             = r_cap;
        o_result.final_tuple = r_final;
    end

endmodule

// ===== design/k_permutation_enumerator.sv =====
// Top level of the k-permutation enumerator: stream ports, register port, output word register.
//
// Each input word asks for the current tuple and advances the enumeration. A small
// microcode program drives the datapath one operation per cycle until the result is
// loaded into the output register: an exhausted sequence goes straight to the load; a
// plain next ordering scans, swaps and reverses; else the prefix is reversed and the next
// combination is taken by a swap and two rotations, or, with none left, the length
// grows or the last tuple is flagged, and full length also steps to the next ordering.
// The input side accepts again the cycle after the result is loaded; a result waiting
// on the output holds the next result back at its last step. symbol_count lives at byte
// address 0 and is to be written only while the block is idle; the block does not enforce it.
module k_permutation_enumerator
    import kpe_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [0] restart, [7:1] zero
    // output stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata,   // [2:0] tuple_length, [4:3] index_0, [6:5] index_1,
                                     // [8:7] index_2, [10:9] index_3, [15:11] zero
    output logic        o_m_tuser,   // [0] tuple_valid
    output logic        o_m_tlast,   // final_tuple
    // register port
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [1:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    output logic [31:0] o_prdata,
    output logic        o_pready
);

    logic             w_cnt_wr;
    logic [CNT_W-1:0] r_symbol_count;
    logic             w_busy;
    logic             w_start;
    logic             w_out_free;
    t_ctl             w_ctl;
    t_flags           w_flags;
    t_result          w_result;
    logic             r_m_valid;
    t_result          r_m_word;

    // register port
    assign o_pready = 1'b1;
    assign o_prdata = (i_paddr == ADDR_SYMBOL_COUNT) ? {{(32-CNT_W){1'b0}}, r_symbol_count}
                                                     : '0;
    assign w_cnt_wr = i_psel && i_penable && i_pwrite && (i_paddr == ADDR_SYMBOL_COUNT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_symbol_count <= CNT_W'(MAX_SYMBOLS);
        end else if (w_cnt_wr) begin
            r_symbol_count <= i_pwdata[CNT_W-1:0];
        end
    end

    // handshakes
    assign o_s_tready = !w_busy;
    assign w_start    = i_s_tvalid && !w_busy;
    assign w_out_free = !r_m_valid || i_m_tready;

    kpe_useq u_useq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_start),
        .i_out_free (w_out_free),
        .i_flags    (w_flags),
        .o_busy     (w_busy),
        .o_ctl      (w_ctl)
    );

    kpe_dpath u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (w_start),
        .i_restart      (i_s_tdata[0]),
        .i_symbol_count (r_symbol_count),
        .i_ctl          (w_ctl),
        .o_flags        (w_flags),
        .o_result       (w_result)
    );

    // output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_ctl.emit) begin
            r_m_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ctl.emit) begin
            r_m_word <= w_result;
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = {5'b0, r_m_word.indices[3], r_m_word.indices[2],
                         r_m_word.indices[1], r_m_word.indices[0], r_m_word.tuple_length};
    assign o_m_tuser  = r_m_word.tuple_valid;
    assign o_m_tlast  = r_m_word.final_tuple;

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the k-permutation enumerator: stream driver, result monitor, tuple predictor.
module testbench;
    import kpe_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int          SETTLE      = 12;   // wait after the queues empty, past the longest word program
    localparam int          LONG_HOLD   = 300;

    // one queued request word, or a marker that makes the sender wait for all results
    typedef struct packed {
        bit hold_for_drain;
        bit restart;
    } t_word_req;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [7:0]  s_tdata = '0;
    logic        m_tready = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [1:0]  paddr = '0;
    logic [31:0] pwdata = '0;

    logic        o_s_tready;
    logic        o_m_tvalid;
    logic [15:0] o_m_tdata;
    logic        o_m_tuser;
    logic        o_m_tlast;
    logic [31:0] o_prdata;
    logic        o_pready;

    k_permutation_enumerator u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast),
        .i_psel     (psel),
        .i_penable  (penable),
        .i_pwrite   (pwrite),
        .i_paddr    (paddr),
        .i_pwdata   (pwdata),
        .o_prdata   (o_prdata),
        .o_pready   (o_pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    t_word_req   request_q [$];
    t_result     tuple_exp_q [$];
    int          mismatch_cnt = 0;
    int unsigned cycle_cnt = 0;
    int          src_idle_pct = 9;
    int          snk_idle_pct = 51;
    int          sink_block_req = 0;
    int          sink_block_ack = 0;
    int          sink_block_left = 0;

    // ---------------------------------------------------------------
    // tuple predictor state
    logic [IDX_W-1:0] perm_m [MAX_SYMBOLS];
    int               len_m = 1;
    bit               done_m = 1'b0;
    logic [CNT_W-1:0] count_reg = 3'd4;

    function automatic void ascend();
        for (int i = 0; i < MAX_SYMBOLS; i++) begin
            perm_m[i] = IDX_W'(i);
        end
    endfunction

    function automatic void flip(int lo, int hi);
        logic [IDX_W-1:0] t;
        while (lo + 1 < hi) begin
            t            = perm_m[lo];
            perm_m[lo]   = perm_m[hi-1];
            perm_m[hi-1] = t;
            lo++;
            hi--;
        end
    endfunction

    // moves perm_m[mid..hi) in front of perm_m[lo..mid)
    function automatic void spin(int lo, int mid, int hi);
        logic [IDX_W-1:0] tmp [MAX_SYMBOLS];
        int c;
        c = 0;
        if (lo >= mid || mid >= hi || hi > MAX_SYMBOLS) begin
            return;
        end
        for (int i = mid; i < hi; i++) begin
            tmp[c] = perm_m[i];
            c++;
        end
        for (int i = lo; i < mid; i++) begin
            tmp[c] = perm_m[i];
            c++;
        end
        for (int i = 0; i < c; i++) begin
            perm_m[lo+i] = tmp[i];
        end
    endfunction

    // next lexicographic ordering of the first len entries, 0 on wrap-around
    function automatic bit next_order(int len);
        int i;
        int j;
        logic [IDX_W-1:0] t;
        if (len < 2) begin
            return 1'b0;
        end
        i = len - 1;
        while (i > 0 && !(perm_m[i-1] < perm_m[i])) begin
            i--;
        end
        if (i == 0) begin
            flip(0, len);
            return 1'b0;
        end
        i--;
        j = len - 1;
        while (j > i && !(perm_m[i] < perm_m[j])) begin
            j--;
        end
        t         = perm_m[i];
        perm_m[i] = perm_m[j];
        perm_m[j] = t;
        flip(i + 1, len);
        return 1'b1;
    endfunction

    // next k-subset held in the prefix, rest kept sorted
    function automatic bit next_choice(int k, int n);
        int a;
        int j;
        logic [IDX_W-1:0] t;
        if (n < 2 || k == 0 || k >= n) begin
            return 1'b0;
        end
        a = k;
        while (a != 0) begin
            a--;
            if (perm_m[a] < perm_m[n-1]) begin
                j = k;
                while (j < n - 1 && !(perm_m[a] < perm_m[j])) begin
                    j++;
                end
                t         = perm_m[a];
                perm_m[a] = perm_m[j];
                perm_m[j] = t;
                a++;
                j++;
                spin(a, j, n);
                spin(k, k + (n - j), n);
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic bit advance_tuple(int n);
        int len;
        len = len_m;
        if (next_order(len)) begin
            return 1'b1;
        end
        if (next_choice(len, n)) begin
            return 1'b1;
        end
        len++;
        if (len > n) begin
            return 1'b0;
        end
        len_m = len;
        ascend();
        // full length starts one past the identity ordering
        if (len == n) begin
            void'(next_order(len));
        end
        return 1'b1;
    endfunction

    function automatic void predict_tuple(bit restart);
        int      n;
        t_result r;
        n = int'(count_reg);
        if (n < 1) begin
            n = 1;
        end
        if (n > MAX_SYMBOLS) begin
            n = MAX_SYMBOLS;
        end
        if (restart) begin
            ascend();
            len_m  = 1;
            done_m = 1'b0;
        end
        r = '0;
        // count lowered below the current length ends the sequence
        if (len_m == 0 || len_m > n) begin
            done_m = 1'b1;
        end
        if (!done_m) begin
            r.tuple_length = LEN_W'(len_m);
            for (int t = 0; t < MAX_SYMBOLS; t++) begin
                if (t < len_m) begin
                    r.indices[t] = perm_m[t];
                end
            end
            r.tuple_valid = 1'b1;
            if (!advance_tuple(n)) begin
                done_m        = 1'b1;
                r.final_tuple = 1'b1;
            end
        end
        tuple_exp_q.push_back(r);
    endfunction

    initial begin
        ascend();
    end

    // ---------------------------------------------------------------
    task automatic report_mismatch(input string msg);
        if (mismatch_cnt < 40) begin
            $display("[%0t] mismatch: %s", $realtime, msg);
        end
        mismatch_cnt++;
    endtask

    task automatic check_field(input string name, input int got, input int want);
        if (got != want) begin
            report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
        end
    endtask

    // input word driver
    always @(posedge i_clk) begin
        bit        take;
        bit        give;
        t_word_req nxt;
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else begin
            take = s_tvalid && o_s_tready;
            if (take) begin
                predict_tuple(s_tdata[0]);
            end
            if (!s_tvalid || take) begin
                give = 1'b0;
                nxt  = '0;
                // pause marker clears once every result is back
                if (request_q.size() > 0 && request_q[0].hold_for_drain &&
                    tuple_exp_q.size() == 0) begin
                    void'(request_q.pop_front());
                end
                if (request_q.size() > 0 && !request_q[0].hold_for_drain &&
                    $urandom_range(99) >= src_idle_pct) begin
                    nxt  = request_q.pop_front();
                    give = 1'b1;
                end
                s_tvalid <= give;
                if (give) begin
                    s_tdata <= {7'b0, nxt.restart};
                end
            end
        end
    end

    // long receiver hold-off, counted here
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            sink_block_left <= 0;
        end else if (sink_block_req != sink_block_ack) begin
            sink_block_ack  <= sink_block_req;
            sink_block_left <= LONG_HOLD;
        end else if (sink_block_left > 0) begin
            sink_block_left <= sink_block_left - 1;
        end
    end

    // result monitor and receiver backpressure
    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (o_m_tvalid && m_tready) begin
                if (tuple_exp_q.size() == 0) begin
                    report_mismatch("result word with nothing expected");
                end else begin
                    want = tuple_exp_q.pop_front();
                    check_field("tuple_length", o_m_tdata[2:0], want.tuple_length);
                    check_field("index_0", o_m_tdata[4:3], want.indices[0]);
                    check_field("index_1", o_m_tdata[6:5], want.indices[1]);
                    check_field("index_2", o_m_tdata[8:7], want.indices[2]);
                    check_field("index_3", o_m_tdata[10:9], want.indices[3]);
                    check_field("tuple_valid", o_m_tuser, want.tuple_valid);
                    check_field("final_tuple", o_m_tlast, want.final_tuple);
                end
            end
            m_tready <= (sink_block_left == 0) && ($urandom_range(99) >= snk_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    task automatic queue_word(input bit restart);
        t_word_req w;
        w.hold_for_drain = 1'b0;
        w.restart        = restart;
        request_q.push_back(w);
    endtask

    task automatic queue_drain();
        t_word_req w;
        w.hold_for_drain = 1'b1;
        w.restart        = 1'b0;
        request_q.push_back(w);
    endtask

    // settle and look again, so a word popped in the same step is not missed
    task automatic wait_drained();
        do begin
            while (request_q.size() > 0 || s_tvalid || tuple_exp_q.size() > 0) begin
                @(posedge i_clk);
            end
            repeat (SETTLE) @(posedge i_clk);
        end while (request_q.size() > 0 || s_tvalid || tuple_exp_q.size() > 0);
    endtask

    // register write; only called while the block is idle
    task automatic reg_write(input logic [31:0] val);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_SYMBOL_COUNT;
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!o_pready);
        psel      <= 1'b0;
        penable   <= 1'b0;
        pwrite    <= 1'b0;
        count_reg = val[CNT_W-1:0];
    endtask

    // one word per character, '1' asks for a restart
    task automatic queue_list(input string bits);
        for (int i = 0; i < bits.len(); i++) begin
            queue_word(bits[i] == "1");
        end
    endtask

    initial begin
        int unsigned phase_count [14] = '{4, 1, 3, 0, 2, 7, 4, 5, 3, 6, 2, 4, 4, 3};
        int          eff;
        int          seq_total;
        int          words;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: reset state is the first tuple; tiny counts, zero and saturating count
        queue_list("00010");
        wait_drained();
        reg_write(32'd1);
        queue_list("00010");
        wait_drained();
        reg_write(32'd0);
        queue_list("100");
        wait_drained();
        reg_write(32'd2);
        queue_list("10000");
        wait_drained();
        reg_write(32'd7);
        queue_list("1000");
        wait_drained();

        // random phases: walk long stretches of the sequence, sometimes stop short
        for (int p = 0; p < 14; p++) begin
            if (p == 4) begin
                src_idle_pct <= 51;
                snk_idle_pct <= 9;
            end else if (p == 8) begin
                src_idle_pct <= 0;
                snk_idle_pct <= 0;
            end
            reg_write({29'($urandom()), 3'(phase_count[p])});
            eff = (phase_count[p] < 1) ? 1 :
                  (phase_count[p] > MAX_SYMBOLS) ? MAX_SYMBOLS : int'(phase_count[p]);
            case (eff)
                1:       seq_total = 1;
                2:       seq_total = 3;
                3:       seq_total = 14;
                default: seq_total = 63;
            endcase
            words = (p % 3 == 2) ? $urandom_range(seq_total / 2 + 1, seq_total + 6)
                                 : seq_total + $urandom_range(2, 6);
            // entry without restart keeps the arrangement left by the last phase
            queue_word($urandom_range(1));
            for (int i = 1; i < words; i++) begin
                queue_word($urandom_range(99) < 2);
                if ((p == 2 || p == 6) && i == words / 2) begin
                    queue_drain();
                end
            end
            // receiver holds off while the sender keeps offering
            if (p == 0) begin
                sink_block_req <= sink_block_req + 1;
            end
            wait_drained();
        end

        if (mismatch_cnt == 0 && tuple_exp_q.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ===== k_permutation_enumerator.f =====
design/kpe_pkg.sv
design/kpe_useq.sv
design/kpe_dpath.sv
design/k_permutation_enumerator.sv
tb/testbench.sv
